>>> sv/chs_pkg.sv
// chs_pkg: shared types and constants of the chained hash set insert block.
// No dependencies; used by chs_store and chained_hash_set_insert.
package chs_pkg;

    localparam int KIND_W   = 1;
    localparam int BUCKET_W = 10;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 12;
    localparam int CFG_W    = 11;

    localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FULL    = 3'd2,
        ST_CLEARED = 3'd3,
        ST_RANGE   = 3'd4
    } t_status;

    // Write strobes from the sequencer to the table store.
    typedef struct packed {
        logic head_we;
        logic data_we;
        logic next_we;
    } t_mem_we;

endpackage

>>> sv/chs_store.sv
// chs_store: bucket head, entry link and entry data memories with registered reads.
// Depends on chs_pkg for the write strobe struct.
module chs_store #(
    parameter int HB = 10,
    parameter int IB = 12,
    parameter int EB = 32
) (
    input  logic                i_clk,
    input  chs_pkg::t_mem_we    i_we,
    input  logic [HB-1:0]       i_head_raddr,
    input  logic [HB-1:0]       i_head_waddr,
    input  logic [IB:0]         i_head_wdata,
    output logic [IB:0]         o_head_rdata,
    input  logic [IB-1:0]       i_entry_raddr,
    input  logic [IB-1:0]       i_entry_waddr,
    input  logic [EB-1:0]       i_data_wdata,
    input  logic [IB:0]         i_next_wdata,
    output logic [EB-1:0]       o_data_rdata,
    output logic [IB:0]         o_next_rdata
);
    import chs_pkg::*;

    // Each word of the head and link memories is a valid bit over a slot index.
    logic [IB:0]   head_mem [2**HB];
    logic [IB:0]   next_mem [2**IB];
    logic [EB-1:0] data_mem [2**IB];

    logic [IB:0]   r_head_q;
    logic [IB:0]   r_next_q;
    logic [EB-1:0] r_data_q;

    always_ff @(posedge i_clk) begin
        if (i_we.head_we) begin
            head_mem[i_head_waddr] <= i_head_wdata;
        end
        r_head_q <= head_mem[i_head_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.next_we) begin
            next_mem[i_entry_waddr] <= i_next_wdata;
        end
        r_next_q <= next_mem[i_entry_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.data_we) begin
            data_mem[i_entry_waddr] <= i_data_wdata;
        end
        r_data_q <= data_mem[i_entry_raddr];
    end

    assign o_head_rdata = r_head_q;
    assign o_next_rdata = r_next_q;
    assign o_data_rdata = r_data_q;

endmodule

>>> sv/chained_hash_set_insert.sv
// chained_hash_set_insert: hash set with separate chaining, insert and clear.
// Depends on chs_pkg and instantiates chs_store for the table memories.
//
//   Channel   Direction  Handshake              Payload
//   request   in         i_valid / o_ready      i_kind, i_bucket, i_element_value
//   result    out        o_valid / i_ready      o_status, o_entry_index
//   config    in         i_cfg_we (no wait)     i_cfg_data (bucket count)
//
// One shared compare walks the chain, one entry read per cycle, so the chain
// length sets the time. An insert into an empty bucket passes S_HEAD, S_APPEND
// and S_DONE; an element found in the chain passes S_HEAD, one S_WALK step per
// entry up to the match, and S_DONE; an append behind a chain adds S_APPEND and
// S_LINK after the walk (S_APPEND alone when the table is full and it is dropped).
// An out-of-range bucket goes straight to S_DONE. A clear request sweeps the
// bucket heads one per cycle and then answers; a configuration write runs the
// same sweep with no result.
// Reset (synchronous, active low) starts the same sweep; requests are refused
// until it ends. The next request can be taken at the edge
// after a result is raised. A waiting result does not block the next request,
// but a new result is held back until the previous one is taken.
module chained_hash_set_insert #(
    parameter int BUCKETS      = 1024,
    parameter int CAPACITY     = 4096,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [chs_pkg::KIND_W-1:0]      i_kind,
    input  logic [chs_pkg::BUCKET_W-1:0]    i_bucket,
    input  logic [chs_pkg::VALUE_W-1:0]     i_element_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [chs_pkg::STATUS_W-1:0]    o_status,
    output logic [chs_pkg::INDEX_W-1:0]     o_entry_index,
    input  logic                            i_cfg_we,
    input  logic [chs_pkg::CFG_W-1:0]       i_cfg_data
);
    import chs_pkg::*;

    localparam int HB  = $clog2(BUCKETS);
    localparam int IB  = $clog2(CAPACITY);
    localparam int CB  = $clog2(CAPACITY + 1);
    localparam int BCB = $clog2(BUCKETS + 1);
    localparam int EB  = ELEMENT_BITS;
    localparam int RESET_BC = (1024 > BUCKETS) ? BUCKETS : 1024;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_HEAD,
        S_WALK,
        S_APPEND,
        S_LINK,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [HB-1:0]   r_bidx, n_bidx;
    logic [EB-1:0]   r_elem, n_elem;
    logic [IB-1:0]   r_cur, n_cur;
    logic            r_tail, n_tail;
    logic [CB-1:0]   r_count, n_count;
    logic [BCB-1:0]  r_bucket_count, n_bucket_count;
    logic [HB-1:0]   r_clr, n_clr;
    logic            r_clr_reply, n_clr_reply;
    t_status         r_res_status, n_res_status;
    logic [INDEX_W-1:0] r_res_index, n_res_index;
    logic            r_out_valid, n_out_valid;
    t_status         r_out_status, n_out_status;
    logic [INDEX_W-1:0] r_out_index, n_out_index;

    // Table store interface.
    t_mem_we         mem_we;
    logic [HB-1:0]   head_raddr, head_waddr;
    logic [IB:0]     head_wdata, head_rdata;
    logic [IB-1:0]   entry_raddr, entry_waddr;
    logic [EB-1:0]   data_wdata, data_rdata;
    logic [IB:0]     next_wdata, next_rdata;

    // Request fields brought to the internal widths.
    logic [31:0]     bucket_ext;
    logic [HB-1:0]   bucket_idx;
    logic [63:0]     value_ext;
    logic [EB-1:0]   value_keep;
    logic            bucket_bad;
    logic [31:0]     cfg_ext;
    logic [31:0]     cfg_clamped;
    logic [31:0]     slot_ext;
    logic [IB-1:0]   slot;
    logic            table_full;
    logic            accept;
    logic            out_free;

    assign bucket_ext = 32'(i_bucket);
    assign bucket_idx = bucket_ext[HB-1:0];
    assign value_ext  = 64'(i_element_value);
    assign value_keep = value_ext[EB-1:0];
    assign bucket_bad = bucket_ext >= 32'(r_bucket_count);

    // A bucket count of zero is taken as one, and anything above BUCKETS as BUCKETS.
    assign cfg_ext     = 32'(i_cfg_data);
    assign cfg_clamped = (cfg_ext == 32'd0) ? 32'd1 :
                         (cfg_ext > 32'(BUCKETS)) ? 32'(BUCKETS) : cfg_ext;

    // The next free slot is the entry count itself.
    assign slot_ext   = 32'(r_count);
    assign slot       = r_count[IB-1:0];
    assign table_full = r_count >= CB'(CAPACITY);

    // Requests are refused in the cycle of a configuration write.
    assign o_ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state        = r_state;
        n_bidx         = r_bidx;
        n_elem         = r_elem;
        n_cur          = r_cur;
        n_tail         = r_tail;
        n_count        = r_count;
        n_bucket_count = r_bucket_count;
        n_clr          = r_clr;
        n_clr_reply    = r_clr_reply;
        n_res_status   = r_res_status;
        n_res_index    = r_res_index;
        n_out_valid    = r_out_valid && !i_ready;
        n_out_status   = r_out_status;
        n_out_index    = r_out_index;

        mem_we      = '0;
        head_raddr  = bucket_idx;
        head_waddr  = r_bidx;
        head_wdata  = {1'b1, slot};
        entry_raddr = r_cur;
        entry_waddr = slot;
        data_wdata  = r_elem;
        next_wdata  = {1'b0, slot};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_CLEAR) begin
                        n_state     = S_CLEAR;
                        n_clr       = '0;
                        n_clr_reply = 1'b1;
                        n_count     = '0;
                    end else if (bucket_bad) begin
                        n_res_status = ST_RANGE;
                        n_res_index  = '0;
                        n_state      = S_DONE;
                    end else begin
                        // Head read is issued now, its data arrives in S_HEAD.
                        n_bidx  = bucket_idx;
                        n_elem  = value_keep;
                        n_state = S_HEAD;
                    end
                end
            end
            S_CLEAR: begin
                mem_we.head_we = 1'b1;
                head_waddr     = r_clr;
                head_wdata     = '0;
                if (r_clr == HB'(BUCKETS - 1)) begin
                    if (r_clr_reply) begin
                        n_res_status = ST_CLEARED;
                        n_res_index  = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_clr = r_clr + HB'(1);
                end
            end
            S_HEAD: begin
                if (head_rdata[IB]) begin
                    entry_raddr = head_rdata[IB-1:0];
                    n_cur       = head_rdata[IB-1:0];
                    n_state     = S_WALK;
                end else begin
                    n_tail  = 1'b0;
                    n_state = S_APPEND;
                end
            end
            S_WALK: begin
                // One compare per visited entry; the next link is fetched meanwhile.
                if (data_rdata == r_elem) begin
                    n_res_status = ST_PRESENT;
                    n_res_index  = '0;
                    n_state      = S_DONE;
                end else if (next_rdata[IB]) begin
                    entry_raddr = next_rdata[IB-1:0];
                    n_cur       = next_rdata[IB-1:0];
                end else begin
                    n_tail  = 1'b1;
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                if (table_full) begin
                    n_res_status = ST_FULL;
                    n_res_index  = '0;
                    n_state      = S_DONE;
                end else begin
                    mem_we.data_we = 1'b1;
                    mem_we.next_we = 1'b1;
                    if (r_tail) begin
                        n_state = S_LINK;
                    end else begin
                        mem_we.head_we = 1'b1;
                        n_res_status   = ST_ADDED;
                        n_res_index    = slot_ext[INDEX_W-1:0];
                        n_count        = r_count + CB'(1);
                        n_state        = S_DONE;
                    end
                end
            end
            S_LINK: begin
                // The old tail now points at the new slot.
                mem_we.next_we = 1'b1;
                entry_waddr    = r_cur;
                next_wdata     = {1'b1, slot};
                n_res_status   = ST_ADDED;
                n_res_index    = slot_ext[INDEX_W-1:0];
                n_count        = r_count + CB'(1);
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = r_res_index;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A configuration write sets the bucket count and starts a fresh sweep.
        if (i_cfg_we) begin
            n_bucket_count = BCB'(cfg_clamped);
            n_count        = '0;
            n_clr          = '0;
            n_clr_reply    = 1'b0;
            n_state        = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_count        <= '0;
            r_bucket_count <= BCB'(RESET_BC);
            r_clr          <= '0;
            r_clr_reply    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_bucket_count <= n_bucket_count;
            r_clr          <= n_clr;
            r_clr_reply    <= n_clr_reply;
            r_out_valid    <= n_out_valid;
        end
        r_bidx       <= n_bidx;
        r_elem       <= n_elem;
        r_cur        <= n_cur;
        r_tail       <= n_tail;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
    end

    chs_store #(
        .HB (HB),
        .IB (IB),
        .EB (EB)
    ) u_store (
        .i_clk         (i_clk),
        .i_we          (mem_we),
        .i_head_raddr  (head_raddr),
        .i_head_waddr  (head_waddr),
        .i_head_wdata  (head_wdata),
        .o_head_rdata  (head_rdata),
        .i_entry_raddr (entry_raddr),
        .i_entry_waddr (entry_waddr),
        .i_data_wdata  (data_wdata),
        .i_next_wdata  (next_wdata),
        .o_data_rdata  (data_rdata),
        .o_next_rdata  (next_rdata)
    );

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = r_out_index;

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(CAPACITY))
        else $error("entry count above capacity");

    // No element is stored once the table is full.
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we.data_we |-> !table_full)
        else $error("element written into a full table");

    // Linking behind a tail always follows the append step.
    a_link_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> ($past(r_state) == S_APPEND))
        else $error("link step without append");

    // A new result only comes from the delivery step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside delivery");

    // An added element has always been counted by the time it is delivered.
    a_added_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == ST_ADDED) |-> (r_count != '0))
        else $error("element added without entry count");

endmodule

>>> bench/tb.sv
// tb: self-checking testbench for chained_hash_set_insert, the chained hash set insert block.
// Depends on chs_pkg and the block itself; everything else is built in.
`timescale 1ns / 100ps

module tb;
    import chs_pkg::*;

    localparam int BUCKETS      = 1024;
    localparam int CAPACITY     = 4096;
    localparam int ELEMENT_BITS = 32;

    // Run bound in cycles.
    localparam int LIMIT       = 2_000_000;
    // The result side stops taking results for a long stretch once, so that the
    // block holds a result back and has to refuse requests for a while.
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BUCKET_W-1:0] bucket;
        logic [VALUE_W-1:0]  element;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] slot;
    } t_answer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [KIND_W-1:0]   i_kind = KIND_INSERT;
    logic [BUCKET_W-1:0] i_bucket = '0;
    logic [VALUE_W-1:0]  i_element_value = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_entry_index;
    logic                i_cfg_we = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    chained_hash_set_insert #(
        .BUCKETS      (BUCKETS),
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_bucket        (i_bucket),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_entry_index   (o_entry_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    // Requests waiting to be sent, answers waiting to come back, and the inserts
    // sent since the table was last emptied (the pool for repeated elements).
    t_request pending_requests[$];
    t_answer  expected_answers[$];
    t_request sent_inserts[$];

    // Our own copy of the table: chain heads, chain links, stored elements and
    // the fill level, plus the bucket count in force.
    logic               head_used[BUCKETS];
    logic [INDEX_W-1:0] head_slot[BUCKETS];
    logic               link_used[CAPACITY];
    logic [INDEX_W-1:0] link_slot[CAPACITY];
    logic [VALUE_W-1:0] slot_element[CAPACITY];
    int unsigned        slots_used;
    int unsigned        buckets_live;

    int unsigned fail_count = 0;
    int unsigned cycles = 0;
    logic        req_taken = 1'b0;
    logic        res_taken = 1'b0;

    // Driver and receiver pacing.
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned hold_left = 0;
    int unsigned results_seen = 0;
    bit          send_quiet = 1'b0;
    bit          recv_quiet = 1'b1;
    t_request    launch;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Emptying the table drops every chain head and restarts allocation at
    // slot zero; the slots themselves keep their stale contents, which no
    // chain can reach any more.
    task automatic table_clear();
        for (int b = 0; b < BUCKETS; b++) begin
            head_used[b] = 1'b0;
        end
        slots_used = 0;
    endtask

    // A write of the bucket count saturates the value into 1..BUCKETS and
    // empties the table, just as a clear request does.
    task automatic bucket_count_write(input logic [CFG_W-1:0] count);
        if (count == 0) begin
            buckets_live = 1;
        end else if (count > BUCKETS) begin
            buckets_live = BUCKETS;
        end else begin
            buckets_live = 32'(count);
        end
        table_clear();
    endtask

    // Works out the answer to one request and updates the table copy. The
    // chain is searched before the fill level is looked at, so an element that
    // is already there is reported as present even in a full table.
    task automatic table_insert(input t_request req, output t_answer ans);
        logic [INDEX_W-1:0] cur;
        int unsigned        steps;
        bit                 walked;
        bit                 hit;
        bit                 done;

        ans.status = ST_ADDED;
        ans.slot   = '0;
        if (req.kind == KIND_CLEAR) begin
            table_clear();
            ans.status = ST_CLEARED;
        end else if (req.bucket >= buckets_live) begin
            ans.status = ST_RANGE;
        end else begin
            cur    = '0;
            walked = 1'b0;
            hit    = 1'b0;
            if (head_used[req.bucket]) begin
                cur    = head_slot[req.bucket];
                walked = 1'b1;
                done   = 1'b0;
                steps  = 0;
                while (!done && steps < CAPACITY) begin
                    if (slot_element[cur] == req.element) begin
                        hit  = 1'b1;
                        done = 1'b1;
                    end else if (!link_used[cur]) begin
                        done = 1'b1;
                    end else begin
                        cur = link_slot[cur];
                    end
                    steps++;
                end
            end
            if (hit) begin
                ans.status = ST_PRESENT;
            end else if (slots_used >= CAPACITY) begin
                ans.status = ST_FULL;
            end else begin
                // The new element goes into the next free slot and is hung
                // behind the chain tail, or becomes the head of an empty bucket.
                slot_element[slots_used[INDEX_W-1:0]] = req.element;
                link_used[slots_used[INDEX_W-1:0]]    = 1'b0;
                if (walked) begin
                    link_used[cur] = 1'b1;
                    link_slot[cur] = slots_used[INDEX_W-1:0];
                end else begin
                    head_used[req.bucket] = 1'b1;
                    head_slot[req.bucket] = slots_used[INDEX_W-1:0];
                end
                ans.slot = slots_used[INDEX_W-1:0];
                slots_used++;
            end
        end
    endtask

    function automatic int unsigned pick_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Queues one request. A clear empties the table, so the pool of elements
    // to repeat starts afresh.
    task automatic queue_request(input logic [KIND_W-1:0] kind,
                                 input logic [BUCKET_W-1:0] bucket,
                                 input logic [VALUE_W-1:0] element);
        t_request req;

        req = '{kind, bucket, element};
        pending_requests.push_back(req);
        if (kind == KIND_CLEAR) begin
            sent_inserts.delete();
        end else begin
            sent_inserts.push_back(req);
        end
    endtask

    // A phase of random traffic. Most requests are inserts into buckets in use;
    // the rest are clears, inserts of elements sent earlier into the same
    // bucket, and inserts aimed at any bucket at all, which with a small bucket
    // count mostly fall out of range. Element values come partly from a small
    // pool so that equal elements meet in a chain now and then.
    task automatic random_phase(input int n, input int clear_pct,
                                input int repeat_pct, input int wide_pct);
        t_request            pick;
        logic [BUCKET_W-1:0] bucket;
        logic [VALUE_W-1:0]  element;

        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < clear_pct) begin
                queue_request(KIND_CLEAR, BUCKET_W'($urandom), $urandom);
            end else if ($urandom_range(0, 99) < repeat_pct && sent_inserts.size() > 0) begin
                pick = sent_inserts[$urandom_range(0, sent_inserts.size() - 1)];
                queue_request(KIND_INSERT, pick.bucket, pick.element);
            end else begin
                if ($urandom_range(0, 99) < wide_pct) begin
                    bucket = BUCKET_W'($urandom_range(0, BUCKETS - 1));
                end else begin
                    bucket = BUCKET_W'($urandom_range(0, buckets_live - 1));
                end
                case ($urandom_range(0, 7))
                    0:       element = $urandom_range(0, 15);
                    1:       element = 32'hFFFF_FFF0 | $urandom_range(0, 15);
                    default: element = $urandom;
                endcase
                queue_request(KIND_INSERT, bucket, element);
            end
        end
    endtask

    // Waits until every request has gone out and every answer has come back,
    // then lets a full sweep of the bucket heads pass before moving on.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_valid || expected_answers.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (BUCKETS + 16) @(negedge i_clk);
    endtask

    // The register is written only while the block is idle; the generator
    // then picks buckets against the count now in force.
    task automatic set_bucket_count(input logic [CFG_W-1:0] count);
        @(negedge i_clk);
        i_cfg_data <= count;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sent_inserts.delete();
    endtask

    // Request driver: a new request is put up at the falling edge once the
    // previous one has been taken and its drawn pause has run out. Valid is
    // written once per edge, so back-to-back requests keep it high.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                launch = pending_requests.pop_front();
                i_kind          <= launch.kind;
                i_bucket        <= launch.bucket;
                i_element_value <= launch.element;
                i_valid         <= 1'b1;
                if ($urandom_range(0, 47) == 0) begin
                    send_quiet = !send_quiet;
                end
                send_gap <= pick_wait(send_quiet);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: after each result it draws a pause, and once in the run
    // it holds off for a long stretch, counted here in cycles.
    always @(negedge i_clk) begin
        if (res_taken) begin
            results_seen++;
            if (results_seen == HOLD_AT) begin
                hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(0, 47) == 0) begin
                recv_quiet = !recv_quiet;
            end
            recv_gap = pick_wait(recv_quiet);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // At each rising edge: check a result that is taken against the oldest
    // answer waiting, then apply a register write or a request that is taken to
    // the table copy. A result passes S_DONE and the output register after its
    // request is taken, so checking first never sees its own request's answer.
    always @(posedge i_clk) begin
        t_answer ans;

        cycles    <= cycles + 1;
        req_taken <= i_valid && o_ready;
        res_taken <= o_valid && i_ready;
        if (!i_rst_n) begin
            bucket_count_write(CFG_W'(BUCKETS));
        end else begin
            if (o_valid && i_ready) begin
                if (expected_answers.size() == 0) begin
                    $error("result with no request outstanding: status %0d, entry_index %0d",
                           o_status, o_entry_index);
                    fail_count++;
                end else begin
                    ans = expected_answers.pop_front();
                    if (o_status !== ans.status) begin
                        $error("status: expected %0d, actual %0d", ans.status, o_status);
                        fail_count++;
                    end
                    if (o_entry_index !== ans.slot) begin
                        $error("entry_index: expected %0d, actual %0d",
                               ans.slot, o_entry_index);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                bucket_count_write(i_cfg_data);
            end
            if (i_valid && o_ready) begin
                table_insert('{i_kind, i_bucket, i_element_value}, ans);
                expected_answers.push_back(ans);
            end
        end
        if (cycles == LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests with the bucket count left at its reset value:
        // growing a chain, finding an element at its head, middle and tail, the
        // top bucket, an equal element in another bucket, and a clear whose
        // bucket and element fields are all ones and must be ignored.
        queue_request(KIND_INSERT, 10'd0,   32'h0000_0000);
        queue_request(KIND_INSERT, 10'd0,   32'h0000_0000);
        queue_request(KIND_INSERT, 10'd0,   32'hFFFF_FFFF);
        queue_request(KIND_INSERT, 10'd0,   32'hAAAA_AAAA);
        queue_request(KIND_INSERT, 10'd0,   32'hFFFF_FFFF);
        queue_request(KIND_INSERT, 10'd0,   32'hAAAA_AAAA);
        queue_request(KIND_INSERT, 10'h3FF, 32'h5555_5555);
        queue_request(KIND_INSERT, 10'h3FF, 32'h5555_5555);
        queue_request(KIND_INSERT, 10'd1,   32'h0000_0000);
        queue_request(KIND_CLEAR,  10'h3FF, 32'hFFFF_FFFF);
        queue_request(KIND_INSERT, 10'd0,   32'h0000_0000);
        queue_request(KIND_INSERT, 10'h3FF, 32'h0000_0000);
        queue_request(KIND_CLEAR,  10'd0,   32'h0000_0000);
        wait_drained();

        // A written count of zero is taken as one bucket: only bucket zero is
        // in range, and its single chain gets long.
        set_bucket_count(11'd0);
        queue_request(KIND_INSERT, 10'd1,   32'h1234_5678);
        queue_request(KIND_INSERT, 10'h3FF, 32'h1234_5678);
        queue_request(KIND_INSERT, 10'd0,   32'h1234_5678);
        queue_request(KIND_INSERT, 10'd0,   32'h1234_5678);
        random_phase(200, 3, 20, 30);
        wait_drained();

        // A count above the bucket total saturates to it. Spread fresh
        // elements over many buckets, then mix repeats with new elements,
        // then clear and refill.
        set_bucket_count(11'h7FF);
        random_phase(500, 0, 0, 0);
        random_phase(80, 0, 50, 0);
        queue_request(KIND_CLEAR, BUCKET_W'($urandom), $urandom);
        random_phase(20, 0, 0, 0);
        wait_drained();

        set_bucket_count(11'd1);
        random_phase(200, 3, 25, 30);
        wait_drained();

        set_bucket_count(11'd2);
        random_phase(200, 3, 25, 30);
        wait_drained();

        set_bucket_count(CFG_W'($urandom_range(3, BUCKETS)));
        random_phase(250, 2, 20, 20);
        wait_drained();

        set_bucket_count(CFG_W'(BUCKETS + 1));
        random_phase(250, 2, 20, 10);
        wait_drained();

        set_bucket_count(CFG_W'(BUCKETS));
        random_phase(150, 2, 20, 0);
        wait_drained();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/chs_pkg.sv
sv/chs_store.sv
sv/chained_hash_set_insert.sv
bench/tb.sv
